>>> hdl/c3zp_pkg.sv
// Shared types and constants of the 3x3 zero-padded stream convolution.
`default_nettype none

package c3zp_pkg;

    localparam int PIX_W        = 16;
    localparam int COEF_W       = 16;
    localparam int OUT_W        = 24;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 21;
    localparam int COEF_ROW_W   = 48;
    localparam int ROW_W        = 22;
    localparam int CFG_IDX_W    = 3;
    localparam int PROD_W       = 32;
    localparam int ROWSUM_W     = 34;
    localparam int SUM_W        = 36;

    localparam int MQ_DEPTH     = 4;
    localparam int MQ_CNT_W     = 3;
    localparam int OQ_DEPTH     = 8;
    localparam int OQ_CNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

    typedef struct packed {
        logic top_off;
        logic bot_off;
        logic left_off;
        logic right_off;
        logic frame_end;
    } bound_t;

    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        bound_t                     bound;
    } work_t;

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        logic             row_end;
        logic             frame_end;
    } result_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
        logic                    restart;
    } frame_cfg_t;

    typedef struct packed {
        logic [COEF_ROW_W-1:0] top;
        logic [COEF_ROW_W-1:0] middle;
        logic [COEF_ROW_W-1:0] bottom;
    } coef_set_t;

endpackage

`default_nettype wire

>>> hdl/c3zp_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none

module c3zp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/c3zp_queue.sv
// Small register FIFO with an occupancy count.
`default_nettype none

module c3zp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           rdata,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);
    assign rdata  = mem[rd_ptr_reg];
    assign count  = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/c3zp_front.sv
// Front end: request intake, raster position, line stores, 3x3 window and border flags.
`default_nettype none

module c3zp_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [c3zp_pkg::PIX_W-1:0]    pixel,
    input  wire logic                          flush,
    input  wire c3zp_pkg::frame_cfg_t          frame_cfg,
    input  wire logic [c3zp_pkg::MQ_CNT_W-1:0] mq_level,
    output logic                               mq_push,
    output c3zp_pkg::work_t                    mq_data
);

    import c3zp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    wm1;
    logic [ROW_W-1:0] hm1;
    logic             accept;
    logic [PIX_W-1:0] px;
    logic             col_zero;
    logic             produce;
    logic             last_frame;
    bound_t           bound;

    logic             b_valid_reg;
    logic [CW-1:0]    b_col_reg;
    logic [PIX_W-1:0] b_px_reg;
    logic             b_produce_reg;
    bound_t           b_bound_reg;
    logic             b_byp_reg, byp_next;
    logic [PIX_W-1:0] b_byp_data_reg;

    logic [PIX_W-1:0] lower_rd;
    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] upper_px;

    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next, win_shift;

    always_comb
    begin
        if (frame_cfg.width == '0)
        begin
            wm1 = '0;
        end
        else if (32'(frame_cfg.width) > 32'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(frame_cfg.width - 1'b1);
        end
        hm1 = (frame_cfg.height == '0) ? '0 : ROW_W'(frame_cfg.height - 1'b1);
    end

    assign full   = (32'(mq_level) + 32'(b_valid_reg)) >= MQ_DEPTH;
    assign accept = push && !full;
    assign px     = flush ? '0 : pixel;

    // Position of the centre pixel relative to the incoming one: one row and one column back.
    always_comb
    begin
        col_zero        = (col_reg == '0);
        produce         = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && !col_zero);
        bound.top_off   = col_zero ? (row_reg == ROW_W'(2)) : (row_reg == ROW_W'(1));
        bound.bot_off   = col_zero ? (row_reg == hm1 + ROW_W'(2)) : (row_reg == hm1 + ROW_W'(1));
        bound.left_off  = (col_reg == CW'(1)) || (col_zero && (wm1 == '0));
        bound.right_off = col_zero;
        last_frame      = produce && col_zero && bound.bot_off;
        bound.frame_end = last_frame;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (frame_cfg.restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_frame)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == wm1)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Upper store write is registered; forward it when the next request hits that column.
    assign byp_next = b_valid_reg && (b_col_reg == col_reg);
    assign upper_px = b_byp_reg ? b_byp_data_reg : upper_rd;

    c3zp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lower_store (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (px),
        .raddr (col_reg),
        .rdata (lower_rd)
    );

    c3zp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_col_reg),
        .wdata (lower_rd),
        .raddr (col_reg),
        .rdata (upper_rd)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_shift[r][0] = win_reg[r][1];
            win_shift[r][1] = win_reg[r][2];
        end
        win_shift[0][2] = upper_px;
        win_shift[1][2] = lower_rd;
        win_shift[2][2] = b_px_reg;

        if (frame_cfg.restart)
        begin
            win_next = '0;
        end
        else if (b_valid_reg)
        begin
            win_next = (b_produce_reg && b_bound_reg.frame_end) ? '0 : win_shift;
        end
        else
        begin
            win_next = win_reg;
        end
    end

    assign mq_push       = b_valid_reg && b_produce_reg;
    assign mq_data.win   = win_shift;
    assign mq_data.bound = b_bound_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_byp_reg   <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
            b_byp_reg   <= byp_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg      <= col_reg;
            b_px_reg       <= px;
            b_produce_reg  <= produce;
            b_bound_reg    <= bound;
            b_byp_data_reg <= lower_rd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/c3zp_back.sv
// Back end: masked 3x3 multiply, adder tree, rounding, saturation and result FIFO.
`default_nettype none

module c3zp_back #(
    parameter int COEF_FRAC_BITS = 12
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire c3zp_pkg::coef_set_t  coefs,
    input  wire logic                 mq_nonempty,
    output logic                      mq_pop,
    input  wire c3zp_pkg::work_t      mq_data,
    input  wire logic                 pop,
    output logic                      empty,
    output c3zp_pkg::result_t         result
);

    import c3zp_pkg::*;

    localparam logic [SUM_W:0]           RND_X2 = (SUM_W + 1)'(1) << COEF_FRAC_BITS;
    localparam logic signed [SUM_W-1:0]  RND    = RND_X2[SUM_W:1];
    localparam logic signed [SUM_W-1:0]  SAT_HI = {{(SUM_W - OUT_W + 1){1'b0}},
                                                   {(OUT_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SAT_LO = {{(SUM_W - OUT_W + 1){1'b1}},
                                                   {(OUT_W - 1){1'b0}}};

    function automatic logic signed [ROWSUM_W-1:0] ext_prod(logic signed [PROD_W-1:0] v);
        return {{(ROWSUM_W - PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] ext_row(logic signed [ROWSUM_W-1:0] v);
        return {{(SUM_W - ROWSUM_W){v[ROWSUM_W-1]}}, v};
    endfunction

    logic [OQ_CNT_W-1:0]  occ_reg, occ_next;
    logic [OQ_CNT_W-1:0]  oq_count;
    logic                 out_pop;
    logic [COEF_ROW_W-1:0] coef_row [3];
    logic [2:0][2:0][COEF_W-1:0] k_sel;
    logic                 row_on [3];
    logic                 col_on [3];

    logic                      s1_valid_reg;
    logic signed [PROD_W-1:0]  s1_prod_reg [3][3];
    logic                      s1_row_end_reg, s1_frame_end_reg;

    logic                      s2_valid_reg;
    logic signed [ROWSUM_W-1:0] s2_row_reg [3];
    logic                      s2_row_end_reg, s2_frame_end_reg;

    logic                      s3_valid_reg;
    logic signed [SUM_W-1:0]   s3_sum_reg;
    logic                      s3_row_end_reg, s3_frame_end_reg;

    logic signed [SUM_W-1:0]   shifted;
    result_t                   res_in;
    result_t                   res_out;

    // Occupancy covers the adder pipeline plus the result FIFO, so issue never overruns it.
    assign out_pop  = pop && !empty;
    assign mq_pop   = mq_nonempty && (occ_reg < OQ_CNT_W'(OQ_DEPTH));
    assign occ_next = occ_reg + OQ_CNT_W'(mq_pop) - OQ_CNT_W'(out_pop);

    always_comb
    begin
        coef_row[0] = coefs.top;
        coef_row[1] = coefs.middle;
        coef_row[2] = coefs.bottom;
        row_on[0]   = !mq_data.bound.top_off;
        row_on[1]   = 1'b1;
        row_on[2]   = !mq_data.bound.bot_off;
        col_on[0]   = !mq_data.bound.left_off;
        col_on[1]   = 1'b1;
        col_on[2]   = !mq_data.bound.right_off;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                k_sel[r][c] = (row_on[r] && col_on[c]) ? coef_row[r][COEF_W*c +: COEF_W] : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_next;
            s1_valid_reg <= mq_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_prod_reg[r][c] <= $signed(mq_data.win[r][c]) * $signed(k_sel[r][c]);
            end
            s2_row_reg[r] <= ext_prod(s1_prod_reg[r][0]) + ext_prod(s1_prod_reg[r][1])
                             + ext_prod(s1_prod_reg[r][2]);
        end
        s1_row_end_reg   <= mq_data.bound.right_off;
        s1_frame_end_reg <= mq_data.bound.frame_end;
        s2_row_end_reg   <= s1_row_end_reg;
        s2_frame_end_reg <= s1_frame_end_reg;
        s3_sum_reg       <= ext_row(s2_row_reg[0]) + ext_row(s2_row_reg[1])
                            + ext_row(s2_row_reg[2]) + RND;
        s3_row_end_reg   <= s2_row_end_reg;
        s3_frame_end_reg <= s2_frame_end_reg;
    end

    always_comb
    begin
        shifted = s3_sum_reg >>> COEF_FRAC_BITS;
        if (shifted > SAT_HI)
        begin
            res_in.filtered = SAT_HI[OUT_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            res_in.filtered = SAT_LO[OUT_W-1:0];
        end
        else
        begin
            res_in.filtered = shifted[OUT_W-1:0];
        end
        res_in.row_end   = s3_row_end_reg;
        res_in.frame_end = s3_frame_end_reg;
    end

    c3zp_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OQ_DEPTH)
    ) u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s3_valid_reg),
        .wdata (res_in),
        .pop   (out_pop),
        .rdata (res_out),
        .count (oq_count)
    );

    assign empty  = (oq_count == '0);
    assign result = res_out;

endmodule

`default_nettype wire

>>> hdl/conv3x3_zero_pad_stream_top.sv
// Throughput: one request per cycle on both sides when the output is popped every cycle.
// Completion: a result's neighbourhood is complete with the request one row plus one pixel
// after the centre pixel; from that request the result follows the path below to the ports.
// Path: input register and line-store read, window queue, multiply, row sums, total, FIFO.
// Reset: asynchronous active-low; clears position, window, queues and loads register
// defaults. Line stores are not cleared; their unwritten entries only feed padded taps.
`default_nettype none

module conv3x3_zero_pad_stream_top #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic signed [c3zp_pkg::PIX_W-1:0] pixel,
    input  wire logic                            flush,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [c3zp_pkg::OUT_W-1:0]    filtered,
    output logic                                 row_end,
    output logic                                 frame_end,
    input  wire logic                            cfg_we,
    input  wire logic [c3zp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c3zp_pkg::COEF_ROW_W-1:0] cfg_data
);

    import c3zp_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COEF_ROW_W-1:0]   coef_top_reg, coef_mid_reg, coef_bot_reg;
    frame_cfg_t              frame_cfg;
    coef_set_t               coefs;
    logic                    mq_push;
    work_t                   mq_wdata, mq_rdata;
    logic                    mq_pop;
    logic [MQ_CNT_W-1:0]     mq_level;
    result_t                 result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_REG_W'(640);
            height_reg   <= HEIGHT_REG_W'(480);
            coef_top_reg <= '0;
            coef_mid_reg <= COEF_ROW_W'(4096);
            coef_bot_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg    <= cfg_data[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: height_reg   <= cfg_data[HEIGHT_REG_W-1:0];
                REG_COEF_TOP:     coef_top_reg <= cfg_data;
                REG_COEF_MIDDLE:  coef_mid_reg <= cfg_data;
                REG_COEF_BOTTOM:  coef_bot_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign frame_cfg.width   = width_reg;
    assign frame_cfg.height  = height_reg;
    assign frame_cfg.restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                          (cfg_index == REG_FRAME_HEIGHT));
    assign coefs.top         = coef_top_reg;
    assign coefs.middle      = coef_mid_reg;
    assign coefs.bottom      = coef_bot_reg;

    c3zp_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .flush     (flush),
        .frame_cfg (frame_cfg),
        .mq_level  (mq_level),
        .mq_push   (mq_push),
        .mq_data   (mq_wdata)
    );

    c3zp_queue #(
        .WIDTH ($bits(work_t)),
        .DEPTH (MQ_DEPTH)
    ) u_work_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .wdata (mq_wdata),
        .pop   (mq_pop),
        .rdata (mq_rdata),
        .count (mq_level)
    );

    c3zp_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coefs       (coefs),
        .mq_nonempty (mq_level != '0),
        .mq_pop      (mq_pop),
        .mq_data     (mq_rdata),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    assign filtered  = result.filtered;
    assign row_end   = result.row_end;
    assign frame_end = result.frame_end;

endmodule

`default_nettype wire

>>> hdl/c3zp_checker.sv
// Port-level checks of the convolution top level, bound to every instance.
`default_nettype none

module c3zp_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            full,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire logic [c3zp_pkg::OUT_W-1:0]      filtered,
    input wire logic                            row_end,
    input wire logic                            frame_end
);

    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> (empty && !full))
        else $error("queues not empty during reset");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> row_end)
        else $error("frame end without row end");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(filtered) && $stable(row_end)
                              && $stable(frame_end)))
        else $error("pending result changed before pop");

endmodule

bind conv3x3_zero_pad_stream_top c3zp_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .filtered  (filtered),
    .row_end   (row_end),
    .frame_end (frame_end)
);

`default_nettype wire

>>> tb/conv3x3_result_checker.sv
`timescale 1ns / 100ps
// Watches requests, register writes and pops, predicts the filtered stream and compares.
module conv3x3_result_checker
    import c3zp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic                    full,
    input  wire logic signed [PIX_W-1:0] pixel,
    input  wire logic                    flush,
    input  wire logic                    empty,
    input  wire logic                    pop,
    input  wire logic signed [OUT_W-1:0] filtered,
    input  wire logic                    row_end,
    input  wire logic                    frame_end,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [COEF_ROW_W-1:0]   cfg_data,
    output int                           mismatches,
    output int                           outstanding
);

    localparam int LINE_DEPTH = 1024;
    localparam int FRAC       = 12;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COEF_ROW_W-1:0]   coef_row [3];

    logic signed [PIX_W-1:0] upper_line [LINE_DEPTH];
    logic signed [PIX_W-1:0] lower_line [LINE_DEPTH];
    logic signed [PIX_W-1:0] taps [3][3];
    int unsigned             col_pos;
    int unsigned             row_pos;

    result_t pending_results [$];

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int unsigned active_width();
        if (width_reg == 0)
        begin
            return 1;
        end
        if (width_reg > LINE_DEPTH)
        begin
            return LINE_DEPTH;
        end
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg == 0) ? 1 : 32'(height_reg);
    endfunction

    task automatic restart_frame();
        int i;
        int j;
        for (i = 0; i < 3; i++)
        begin
            for (j = 0; j < 3; j++)
            begin
                taps[i][j] = '0;
            end
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:
            begin
                width_reg = data[WIDTH_REG_W-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT:
            begin
                height_reg = data[HEIGHT_REG_W-1:0];
                restart_frame();
            end
            REG_COEF_TOP:    coef_row[0] = data;
            REG_COEF_MIDDLE: coef_row[1] = data;
            REG_COEF_BOTTOM: coef_row[2] = data;
            default: ;
        endcase
    endtask

    task automatic accept_pixel(logic signed [PIX_W-1:0] value, logic is_flush);
        int unsigned             w;
        int unsigned             h;
        int unsigned             c;
        int unsigned             r;
        int unsigned             crow;
        int unsigned             ccol;
        int                      i;
        int                      j;
        logic signed [PIX_W-1:0] px;
        logic signed [COEF_W-1:0] k;
        longint                  acc;
        longint                  q;
        logic                    last_col;
        result_t                 res;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        px = is_flush ? '0 : value;
        if (c >= w)
        begin
            c = 0;
        end
        for (i = 0; i < 3; i++)
        begin
            taps[i][0] = taps[i][1];
            taps[i][1] = taps[i][2];
        end
        taps[0][2] = upper_line[c];
        taps[1][2] = lower_line[c];
        taps[2][2] = px;
        upper_line[c] = lower_line[c];
        lower_line[c] = px;
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            crow = (c == 0) ? r - 2 : r - 1;
            ccol = (c == 0) ? w - 1 : c - 1;
            last_col = (ccol == w - 1);
            acc = 0;
            for (i = 0; i < 3; i++)
            begin
                for (j = 0; j < 3; j++)
                begin
                    // taps outside the frame are zero padding
                    if (!((i == 0 && crow == 0) || (i == 2 && crow == h - 1) ||
                          (j == 0 && ccol == 0) || (j == 2 && last_col)))
                    begin
                        k = coef_row[i][16*j +: 16];
                        acc += longint'(taps[i][j]) * longint'(k);
                    end
                end
            end
            q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (q > 64'sd8388607)
            begin
                q = 64'sd8388607;
            end
            if (q < -64'sd8388608)
            begin
                q = -64'sd8388608;
            end
            res.filtered  = q[OUT_W-1:0];
            res.row_end   = last_col;
            res.frame_end = last_col && (crow == h - 1);
            pending_results.push_back(res);
            if (res.frame_end)
            begin
                restart_frame();
                return;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: filtered=%0d row_end=%b frame_end=%b",
                                      filtered, row_end, frame_end));
            return;
        end
        want = pending_results.pop_front();
        if (filtered !== want.filtered)
        begin
            report_mismatch($sformatf("filtered %0d, expected %0d",
                                      filtered, $signed(want.filtered)));
        end
        if (row_end !== want.row_end)
        begin
            report_mismatch($sformatf("row_end %b, expected %b", row_end, want.row_end));
        end
        if (frame_end !== want.frame_end)
        begin
            report_mismatch($sformatf("frame_end %b, expected %b", frame_end, want.frame_end));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = 11'd640;
            height_reg  = 21'd480;
            coef_row[0] = '0;
            coef_row[1] = 48'd4096;
            coef_row[2] = '0;
            for (int n = 0; n < LINE_DEPTH; n++)
            begin
                upper_line[n] = '0;
                lower_line[n] = '0;
            end
            restart_frame();
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (pop && !empty)
            begin
                check_result();
            end
            if (push && !full)
            begin
                accept_pixel(pixel, flush);
            end
            outstanding = pending_results.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, pixel requests, register writes, pops and the verdict.
module tb;
    import c3zp_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 200;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    push      = 1'b0;
    logic signed [PIX_W-1:0] pixel     = '0;
    logic                    flush     = 1'b0;
    logic                    pop       = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_FRAME_WIDTH;
    logic [COEF_ROW_W-1:0]   cfg_data  = '0;

    wire logic                    full;
    wire logic                    empty;
    wire logic signed [OUT_W-1:0] filtered;
    wire logic                    row_end;
    wire logic                    frame_end;
    int                           mismatches;
    int                           outstanding;

    logic        steady     = 1'b0;
    int          cycles     = 0;
    int          items_sent = 0;
    int unsigned cur_w      = 640;
    int unsigned cur_h      = 480;
    longint      frame_pos  = 0;

    logic signed [PIX_W-1:0] corner_px [13] = '{
        16'sh7FFF, -16'sh8000, 16'sh7FFF,
        -16'sh8000, 16'sh7FFF, -16'sh8000,
        16'sh5A5A, 16'sh0001, -16'sh0001,
        -16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh1234
    };
    logic corner_fl [13] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                             1'b0, 1'b1, 1'b0};

    conv3x3_zero_pad_stream_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .flush     (flush),
        .empty     (empty),
        .pop       (pop),
        .filtered  (filtered),
        .row_end   (row_end),
        .frame_end (frame_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv3x3_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .flush       (flush),
        .empty       (empty),
        .pop         (pop),
        .filtered    (filtered),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("conv3x3_zero_pad_stream_top verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= steady || ($urandom_range(99) >= 34);
        end
    end

    function automatic logic signed [PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return '0;
            3:       return PIX_W'(int'($urandom_range(255)) - 128);
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_ROW_W-1:0] random_coef_row();
        logic [COEF_ROW_W-1:0] row;
        int                    k;
        for (k = 0; k < 3; k++)
        begin
            case ($urandom_range(5))
                0:       row[16*k +: 16] = 16'h7FFF;
                1:       row[16*k +: 16] = 16'h8000;
                2:       row[16*k +: 16] = 16'($urandom_range(8192));
                default: row[16*k +: 16] = 16'($urandom);
            endcase
        end
        return row;
    endfunction

    function automatic longint frame_total();
        return longint'(cur_w) * cur_h + cur_w + 1;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic signed [PIX_W-1:0] value, logic is_flush);
        while (!steady && $urandom_range(99) < 34)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= value;
        flush <= is_flush;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_stream(longint count);
        longint body;
        body = longint'(cur_w) * cur_h;
        repeat (count)
        begin
            if (frame_pos < body)
            begin
                send_item(random_pixel(), $urandom_range(99) < 5);
            end
            else
            begin
                send_item(random_pixel(), 1'($urandom_range(1)));
            end
            frame_pos++;
            if (frame_pos == body + cur_w + 1)
            begin
                frame_pos = 0;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(logic [WIDTH_REG_W-1:0] w, logic [HEIGHT_REG_W-1:0] h,
                             logic [COEF_ROW_W-1:0] top, logic [COEF_ROW_W-1:0] mid,
                             logic [COEF_ROW_W-1:0] bot, logic coefs_only);
        logic [CFG_IDX_W-1:0]  idx_list [5];
        logic [COEF_ROW_W-1:0] val_list [5];
        int                    i;
        idx_list = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_COEF_TOP, REG_COEF_MIDDLE,
                     REG_COEF_BOTTOM};
        val_list = '{COEF_ROW_W'(w), COEF_ROW_W'(h), top, mid, bot};
        for (i = coefs_only ? 2 : 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        if (!coefs_only)
        begin
            cur_w     = (w == 0) ? 1 : ((w > LINE_DEPTH) ? LINE_DEPTH : 32'(w));
            cur_h     = (h == 0) ? 1 : 32'(h);
            frame_pos = 0;
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int                      random_start;
        int                      i;
        logic                    coefs_only;
        logic [WIDTH_REG_W-1:0]  w_reg;
        logic [HEIGHT_REG_W-1:0] h_reg;
        longint                  total;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // oversized width on default height and default kernel (left neighbour at unit gain), no idling on either side
        steady = 1'b1;
        write_reg(REG_FRAME_WIDTH, COEF_ROW_W'(11'd2047));
        cur_w     = LINE_DEPTH;
        frame_pos = 0;
        send_stream(1060);
        wait_drained();
        steady = 1'b0;

        // saturating corners, flush inside the frame, pixels in the drain
        configure(11'd3, 21'd3, {3{16'h7FFF}}, {3{16'h8000}}, {16'h7FFF, 16'h8000, 16'h7FFF},
                  1'b0);
        for (i = 0; i < 13; i++)
        begin
            send_item(corner_px[i], corner_fl[i]);
        end
        wait_drained();
        configure(11'd1, 21'd1, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(-16'sh8000, 1'b0);
        send_item(16'sh0000, 1'b1);
        wait_drained();
        configure(11'd0, 21'd0, '0, {3{16'h8000}}, '0, 1'b0);
        send_item(-16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b1);
        send_item(16'sh7FFF, 1'b0);
        wait_drained();

        // tall frame cut short, then restarted by the next width write
        configure(11'd5, 21'd2097151, random_coef_row(), random_coef_row(),
                  random_coef_row(), 1'b0);
        send_stream(40);
        wait_drained();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            coefs_only = (frame_pos != 0) && ($urandom_range(2) == 0);
            w_reg = WIDTH_REG_W'(cur_w);
            h_reg = HEIGHT_REG_W'(cur_h);
            if (!coefs_only)
            begin
                case ($urandom_range(9))
                    0:       w_reg = '0;
                    1:       w_reg = WIDTH_REG_W'(1);
                    2:       w_reg = WIDTH_REG_W'(2);
                    3:       w_reg = WIDTH_REG_W'(3);
                    4:       w_reg = WIDTH_REG_W'($urandom_range(17, 64));
                    default: w_reg = WIDTH_REG_W'($urandom_range(4, 16));
                endcase
                h_reg = ($urandom_range(11) == 0) ? '0 : HEIGHT_REG_W'($urandom_range(1, 6));
            end
            configure(w_reg, h_reg, random_coef_row(), random_coef_row(), random_coef_row(),
                      coefs_only);
            total = frame_total();
            if ($urandom_range(3) == 0)
            begin
                send_stream(longint'($urandom_range(1, int'(total) - 1)));
            end
            else
            begin
                send_stream(total - frame_pos + longint'($urandom_range(2)) * total);
            end
            wait_drained();
        end

        if (mismatches == 0)
        begin
            $display("conv3x3_zero_pad_stream_top verification clean");
        end
        else
        begin
            $display("conv3x3_zero_pad_stream_top verification failed");
        end
        $finish;
    end

endmodule
